// ===== rtl/b64url_pkg.sv =====
// ----------------------------------------------------------------------------
// b64url_pkg
// Types, codes and the character mapping for the base64url stream encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64url_pkg;

    localparam int unsigned SEXTET_W = 6;
    localparam int unsigned SYMBOL_W = 7;
    localparam int unsigned BYTE_W   = 8;

    typedef enum logic [1:0] {
        PHASE_FIRST  = 2'd0,
        PHASE_SECOND = 2'd1,
        PHASE_THIRD  = 2'd2
    } phase_t;

    typedef enum logic {
        CMD_DATA = 1'b0,
        CMD_END  = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                last_of_run;
        logic                msg_end;
    } item_t;

    localparam logic [SYMBOL_W-1:0] SYM_TERMINATOR = 7'd0;
    localparam logic [SYMBOL_W-1:0] ASCII_UPPER_A  = 7'd65;
    localparam logic [SYMBOL_W-1:0] ASCII_LOWER_A  = 7'd97;
    localparam logic [SYMBOL_W-1:0] ASCII_ZERO     = 7'd48;
    localparam logic [SYMBOL_W-1:0] ASCII_DASH     = 7'd45;
    localparam logic [SYMBOL_W-1:0] ASCII_UNDER    = 7'd95;

    localparam logic [SEXTET_W-1:0] SEXTET_LOWER = 6'd26;
    localparam logic [SEXTET_W-1:0] SEXTET_DIGIT = 6'd52;
    localparam logic [SEXTET_W-1:0] SEXTET_DASH  = 6'd62;
    localparam logic [SEXTET_W-1:0] SEXTET_UNDER = 6'd63;

    // URL-safe alphabet: A-Z a-z 0-9 - _
    function automatic logic [SYMBOL_W-1:0] sextet_to_ascii(input logic [SEXTET_W-1:0] s);
        logic [SYMBOL_W-1:0] s7;
        logic [SYMBOL_W-1:0] c;
        s7 = {1'b0, s};
        if (s < SEXTET_LOWER) begin
            c = ASCII_UPPER_A + s7;
        end else if (s < SEXTET_DIGIT) begin
            c = ASCII_LOWER_A + s7 - {1'b0, SEXTET_LOWER};
        end else if (s < SEXTET_DASH) begin
            c = ASCII_ZERO + s7 - {1'b0, SEXTET_DIGIT};
        end else if (s == SEXTET_DASH) begin
            c = ASCII_DASH;
        end else begin
            c = ASCII_UNDER;
        end
        return c;
    endfunction

    function automatic item_t make_char(input logic [SEXTET_W-1:0] s, input logic last);
        item_t it;
        it.symbol      = sextet_to_ascii(s);
        it.last_of_run = last;
        it.msg_end     = 1'b0;
        return it;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/base64url_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// base64url_stream_encoder
// Unpadded URL-safe base64 encoder, one raw byte per input item.
// ----------------------------------------------------------------------------
//  channel | ports                                    | direction
//  s_      | s_valid s_ready s_command s_data_byte     | in
//  m_      | m_valid m_ready m_symbol m_last_of_run    | out
//          | m_message_end                             |
//
//  An input item that gives one character yields one result item; a third
//  byte of a group or an end inside a group yields two, one per cycle while
//  m_ready is high on the result port, held in a two-slot result register.
//  Synchronous active-low reset returns to the first byte of a group.
//  A stalled result port holds at most one pending item plus its follower.
// ----------------------------------------------------------------------------
`default_nettype none

module base64url_stream_encoder (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_command,
    input  wire logic [7:0] s_data_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [6:0]      m_symbol,
    output logic            m_last_of_run,
    output logic            m_message_end
);

    b64url_pkg::phase_t                    phase_reg, phase_next;
    logic [b64url_pkg::SEXTET_W-1:0]       pending_reg, pending_next;

    logic             out_valid_reg, out_valid_next;
    logic             has2_reg, has2_next;
    b64url_pkg::item_t item0_reg, item0_next;
    b64url_pkg::item_t item1_reg, item1_next;

    b64url_pkg::item_t new0, new1;
    logic             new_has2;
    logic             accept;
    logic             take;

    assign take    = out_valid_reg & m_ready;
    assign s_ready = ~has2_reg & (~out_valid_reg | m_ready);
    assign accept  = s_valid & s_ready;

    // next phase and pending sextet
    always_comb begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        if (accept) begin
            if (s_command == b64url_pkg::CMD_END) begin
                phase_next   = b64url_pkg::PHASE_FIRST;
                pending_next = '0;
            end else begin
                unique case (phase_reg)
                    b64url_pkg::PHASE_SECOND: begin
                        phase_next   = b64url_pkg::PHASE_THIRD;
                        pending_next = {s_data_byte[3:0], 2'b00};
                    end
                    b64url_pkg::PHASE_THIRD: begin
                        phase_next   = b64url_pkg::PHASE_FIRST;
                        pending_next = '0;
                    end
                    default: begin
                        phase_next   = b64url_pkg::PHASE_SECOND;
                        pending_next = {s_data_byte[1:0], 4'b0000};
                    end
                endcase
            end
        end
    end

    // result items caused by the offered input item
    always_comb begin
        new1.symbol      = b64url_pkg::SYM_TERMINATOR;
        new1.last_of_run = 1'b1;
        new1.msg_end     = 1'b1;
        new_has2         = 1'b0;
        if (s_command == b64url_pkg::CMD_END) begin
            unique case (phase_reg)
                b64url_pkg::PHASE_SECOND, b64url_pkg::PHASE_THIRD: begin
                    new0     = b64url_pkg::make_char(pending_reg, 1'b0);
                    new_has2 = 1'b1;
                end
                default: begin
                    new0 = new1;
                end
            endcase
        end else begin
            unique case (phase_reg)
                b64url_pkg::PHASE_SECOND: begin
                    new0 = b64url_pkg::make_char(pending_reg | {2'b00, s_data_byte[7:4]},
                                                 1'b1);
                end
                b64url_pkg::PHASE_THIRD: begin
                    new0     = b64url_pkg::make_char(pending_reg | {4'b0000, s_data_byte[7:6]},
                                                     1'b0);
                    new1     = b64url_pkg::make_char(s_data_byte[5:0], 1'b1);
                    new_has2 = 1'b1;
                end
                default: begin
                    new0 = b64url_pkg::make_char(s_data_byte[7:2], 1'b1);
                end
            endcase
        end
    end

    // result register: two slots, slot 1 moves up when slot 0 is taken
    always_comb begin
        out_valid_next = out_valid_reg;
        has2_next      = has2_reg;
        item0_next     = item0_reg;
        item1_next     = item1_reg;
        if (take) begin
            if (has2_reg) begin
                item0_next = item1_reg;
                has2_next  = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
        if (accept) begin
            out_valid_next = 1'b1;
            has2_next      = new_has2;
            item0_next     = new0;
            item1_next     = new1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= b64url_pkg::PHASE_FIRST;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
            has2_reg      <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
            has2_reg      <= has2_next;
        end
    end

    always_ff @(posedge aclk) begin
        item0_reg <= item0_next;
        item1_reg <= item1_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_symbol      = item0_reg.symbol;
    assign m_last_of_run = item0_reg.last_of_run;
    assign m_message_end = item0_reg.msg_end;

`ifndef SYNTH
    a_has2_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        has2_reg |-> out_valid_reg)
        else $error("second slot full without a valid first slot");

    a_no_accept_with_follower: assert property (@(posedge aclk) disable iff (!aresetn)
        has2_reg |-> !s_ready)
        else $error("input taken while a follower item is queued");

    a_end_resets_group: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_command == b64url_pkg::CMD_END) |=>
            (phase_reg == b64url_pkg::PHASE_FIRST && pending_reg == '0 && m_valid))
        else $error("end command did not return to group start");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_message_end) |-> (m_last_of_run && m_symbol == b64url_pkg::SYM_TERMINATOR))
        else $error("terminator item malformed");

    a_third_byte_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_command == b64url_pkg::CMD_DATA && phase_reg == b64url_pkg::PHASE_THIRD)
            |=> (has2_reg && !m_last_of_run))
        else $error("third byte did not queue two characters");
`endif

endmodule

`default_nettype wire

// ===== sim/b64url_checker.sv =====
// ----------------------------------------------------------------------------
// b64url_checker
// Watches both channels of the base64url encoder, predicts the characters
// for every accepted item and compares each result item in order.
// ----------------------------------------------------------------------------
module b64url_checker
    import b64url_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_command,
    input  logic [7:0] s_data_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [6:0] m_symbol,
    input  logic       m_last_of_run,
    input  logic       m_message_end,
    output int         mismatch_count,
    output int         symbols_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [8*64-1:0] URL_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
    localparam int REPORT_MAX = 10;

    phase_t      grp_phase;
    logic [5:0]  carry_bits;
    item_t       symbols_due[$];

    function automatic logic [6:0] url_char(input logic [5:0] s);
        logic [7:0] ch;
        ch = URL_ALPHABET[8*(63 - int'(s)) +: 8];
        return ch[6:0];
    endfunction

    function automatic void queue_char(input logic [5:0] s, input logic last);
        item_t it;
        it.symbol      = url_char(s);
        it.last_of_run = last;
        it.msg_end     = 1'b0;
        symbols_due.push_back(it);
    endfunction

    function automatic void encode_item(input logic cmd, input logic [7:0] b);
        item_t term;
        if (cmd == CMD_END) begin
            if (grp_phase == PHASE_SECOND || grp_phase == PHASE_THIRD) begin
                queue_char(carry_bits, 1'b0);
            end
            term.symbol      = SYM_TERMINATOR;
            term.last_of_run = 1'b1;
            term.msg_end     = 1'b1;
            symbols_due.push_back(term);
            grp_phase  = PHASE_FIRST;
            carry_bits = '0;
        end else begin
            case (grp_phase)
                PHASE_SECOND: begin
                    queue_char(carry_bits | {2'b00, b[7:4]}, 1'b1);
                    carry_bits = {b[3:0], 2'b00};
                    grp_phase  = PHASE_THIRD;
                end
                PHASE_THIRD: begin
                    queue_char(carry_bits | {4'b0000, b[7:6]}, 1'b0);
                    queue_char(b[5:0], 1'b1);
                    carry_bits = '0;
                    grp_phase  = PHASE_FIRST;
                end
                default: begin
                    queue_char(b[7:2], 1'b1);
                    carry_bits = {b[1:0], 4'b0000};
                    grp_phase  = PHASE_SECOND;
                end
            endcase
        end
    endfunction

    always @(posedge aclk) begin
        item_t want;
        if (!aresetn) begin
            grp_phase  = PHASE_FIRST;
            carry_bits = '0;
            symbols_due.delete();
        end else begin
            if (s_valid && s_ready) begin
                encode_item(s_command, s_data_byte);
            end
            if (m_valid && m_ready) begin
                if (symbols_due.size() == 0) begin
                    if (mismatch_count < REPORT_MAX) begin
                        $display("%0t: unexpected result symbol %0d last %b end %b",
                                 $realtime, m_symbol, m_last_of_run, m_message_end);
                    end
                    mismatch_count = mismatch_count + 1;
                end else begin
                    want = symbols_due.pop_front();
                    if (m_symbol !== want.symbol || m_last_of_run !== want.last_of_run
                            || m_message_end !== want.msg_end) begin
                        if (mismatch_count < REPORT_MAX) begin
                            $display("%0t: symbol %0d (exp %0d) last %b (exp %b) end %b (exp %b)",
                                     $realtime, m_symbol, want.symbol, m_last_of_run,
                                     want.last_of_run, m_message_end, want.msg_end);
                        end
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
        end
        symbols_pending = symbols_due.size();
    end

    initial begin
        mismatch_count  = 0;
        symbols_pending = 0;
        grp_phase       = PHASE_FIRST;
        carry_bits      = '0;
    end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives byte messages and end commands into the base64url encoder with
// random idling on both sides and one long result stall; the checker
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_top;
    import b64url_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ITEMS        = 650;
    localparam int SQUEEZE_AT     = 250;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int QUIET_LIMIT    = 3000;
    localparam int DRAIN_CYCLES   = 20;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_command;
    logic [7:0] s_data_byte;
    logic       m_valid;
    logic       m_ready;
    logic [6:0] m_symbol;
    logic       m_last_of_run;
    logic       m_message_end;

    int mismatch_count;
    int symbols_pending;
    int items_sent;
    int send_calm;
    int sink_calm;

    base64url_stream_encoder i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_symbol      (m_symbol),
        .m_last_of_run (m_last_of_run),
        .m_message_end (m_message_end)
    );

    b64url_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_symbol        (m_symbol),
        .m_last_of_run   (m_last_of_run),
        .m_message_end   (m_message_end),
        .mismatch_count  (mismatch_count),
        .symbols_pending (symbols_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // calm_left > 0 gives a stretch without idling
    function automatic int idle_cycles(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm_left = $urandom_range(10, 40);
        end
        return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 18));
    endfunction

    task automatic offer(input cmd_t cmd, input logic [7:0] b);
        int gap;
        gap = idle_cycles(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic offer_byte();
        offer(CMD_DATA, 8'($urandom_range(0, 255)));
    endtask

    task automatic offer_end();
        offer(CMD_END, 8'($urandom_range(0, 255)));
    endtask

    initial begin : stimulus
        int kind;
        int len;
        items_sent  = 0;
        send_calm   = 0;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_command   <= CMD_DATA;
        s_data_byte <= 8'h00;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // end right after reset, then ends in every phase
        offer(CMD_END, 8'hA5);
        offer(CMD_DATA, 8'h00);
        offer(CMD_END, 8'h00);
        offer(CMD_DATA, 8'hFF);
        offer(CMD_DATA, 8'hFF);
        offer(CMD_END, 8'hFF);
        offer(CMD_DATA, 8'hFF);
        offer(CMD_DATA, 8'hFF);
        offer(CMD_DATA, 8'hFF);
        // four '-' characters
        offer(CMD_DATA, 8'hFB);
        offer(CMD_DATA, 8'hEF);
        offer(CMD_DATA, 8'hBE);
        offer(CMD_END, 8'h5A);
        offer(CMD_DATA, 8'h03);
        offer(CMD_DATA, 8'hF0);
        offer(CMD_DATA, 8'h0F);
        offer(CMD_DATA, 8'h00);
        offer(CMD_END, 8'hC3);

        while (items_sent < N_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                offer_end();
            end else if (kind == 1) begin
                len = $urandom_range(1, 4);
                repeat (len) offer_byte();
            end else begin
                len = $urandom_range(0, 10);
                repeat (len) offer_byte();
                offer_end();
            end
        end
        s_valid <= 1'b0;

        // let the checker see the last accepted item first
        @(posedge aclk);
        wait (symbols_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && symbols_pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin : result_sink
        int stall;
        bit squeezed;
        squeezed  = 1'b0;
        sink_calm = 0;
        m_ready   <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!squeezed && items_sent >= SQUEEZE_AT) begin
                m_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge aclk);
                squeezed = 1'b1;
            end
            stall = idle_cycles(sink_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
